@@ rtl/display_backend_regs_pixel_unpack_macros.svh @@
// assertion macros used by the display back-end rtl
`ifndef DISPLAY_BACKEND_REGS_PIXEL_UNPACK_MACROS_SVH
`define DISPLAY_BACKEND_REGS_PIXEL_UNPACK_MACROS_SVH

// same-cycle implication, checked on clk with active low reset
`define DBRPU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DBRPU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dbrpu_pkg.sv @@
// shared types and constants of the display back-end register block
`timescale 1ns / 1ps
`default_nettype none

package dbrpu_pkg;

  localparam int REG_WORDS_DEF = 96;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_PIXEL = 2'd2,
    ACT_FRAME = 2'd3
  } action_t;

  localparam logic [3:0] FMT_RGB565   = 4'd5;
  localparam logic [3:0] FMT_RGB0888  = 4'd9;
  localparam logic [3:0] FMT_ARGB8888 = 4'd10;
  localparam logic [3:0] FMT_RGB888   = 4'd11;

  localparam logic [11:0] OFF_MODE  = 12'h800;
  localparam logic [11:0] OFF_SIZE  = 12'h808;
  localparam logic [11:0] OFF_FB_LO = 12'h850;
  localparam logic [11:0] OFF_FB_HI = 12'h860;
  localparam logic [11:0] OFF_ATT1  = 12'h8A0;

  localparam int MODE_EN_BIT    = 0;
  localparam int MODE_START_BIT = 1;
  localparam int OPT_SWAP_BIT   = 2;

  typedef struct packed {
    action_t      action;
    logic [11:0]  offset;
    logic [31:0]  write_data;
    logic [31:0]  pixel_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] pixel_argb;
    logic        refresh_pending;
    logic [11:0] layer_width;
    logic [11:0] layer_height;
    logic [31:0] frame_base;
    logic        output_active;
  } out_item_t;

  // layer-0 pixel format settings handed to the unpacker
  typedef struct packed {
    logic [3:0] code;
    logic [2:0] opts;
  } fmt_t;

endpackage

`default_nettype wire

@@ rtl/dbrpu_chan_if.sv @@
// valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
`default_nettype none

interface dbrpu_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/display_backend_regs_pixel_unpack.sv @@
// display back-end register block with layer-0 pixel unpacker (top level)
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------
//   in_ch   | in  | action, offset, write_data, pixel_word
//   out_ch  | out | read_data, pixel_argb, refresh_pending, layer_width,
//           |     | layer_height, frame_base, output_active
//
// one beat per clock sustained while out_ch is not stalled; an in beat reaches
// out_ch through the input stage holding the register file read, then the result register
// the register file ram is read when a beat is taken, a write one beat
// ahead to the same word is forwarded
// rst_n is synchronous; per-word valid bits make the register file read
// as zero after reset with no clearing pass
// a stall on out_ch holds both stages and drops in_ch.ready only when full
`timescale 1ns / 1ps
`default_nettype none

`include "display_backend_regs_pixel_unpack_macros.svh"

module display_backend_regs_pixel_unpack #(
  parameter int REG_WORDS = dbrpu_pkg::REG_WORDS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  dbrpu_chan_if.sink   in_ch,
  dbrpu_chan_if.source out_ch
);

  localparam int IDX_W = $clog2(REG_WORDS);
  localparam logic [8:0] WORDS_LIM = 9'(REG_WORDS);

  // register window decode: offset at or above 0x800 and word index below REG_WORDS
  function automatic logic in_win(input logic [11:0] off);
    in_win = off[11] && (off[10:2] < WORDS_LIM);
  endfunction

  // input stage
  logic                 s1_valid_r;
  dbrpu_pkg::in_item_t  s1_item_r;
  logic                 s1_rvalid_r;
  logic                 s1_fwd_hit_r;
  logic [31:0]          s1_fwd_data_r;

  // working state
  logic [31:0]          mode_r, mode_nxt;
  logic [31:0]          base_r, base_nxt;
  logic [11:0]          width_r, width_nxt;
  logic [11:0]          height_r, height_nxt;
  dbrpu_pkg::fmt_t      fmt_r, fmt_nxt;
  logic                 redraw_r, redraw_nxt;
  logic [REG_WORDS-1:0] wvalid_r;

  // result register
  logic                 out_valid_r;
  dbrpu_pkg::out_item_t out_item_r;

  logic                 advance;
  logic                 in_ready;
  logic                 accept;
  logic                 fire;
  logic [IDX_W-1:0]     in_idx;
  logic [IDX_W-1:0]     wr_idx;
  logic                 wr_en;
  logic                 s1_win;
  logic [31:0]          ram_rdata;
  logic [31:0]          rd_word;
  logic [31:0]          argb;
  logic [11:0]          size_w;
  logic [11:0]          size_h;
  logic                 active_nxt;

  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_ch.valid && in_ready;
  assign fire     = s1_valid_r && advance;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  assign in_idx = in_ch.data.offset[IDX_W+1:2];
  assign wr_idx = s1_item_r.offset[IDX_W+1:2];
  assign s1_win = in_win(s1_item_r.offset);

  // while disabled only the mode word is stored
  assign wr_en = fire && (s1_item_r.action == dbrpu_pkg::ACT_WRITE) && s1_win &&
                 (mode_r[dbrpu_pkg::MODE_EN_BIT] ||
                  (s1_item_r.offset == dbrpu_pkg::OFF_MODE));

  dbrpu_ram #(
    .WIDTH (32),
    .DEPTH (REG_WORDS)
  ) u_regfile (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (s1_item_r.write_data),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  dbrpu_unpack u_unpack (
    .fmt        (fmt_r),
    .pixel_word (s1_item_r.pixel_word),
    .argb       (argb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r     <= in_ch.data;
      s1_rvalid_r   <= in_win(in_ch.data.offset) && wvalid_r[in_idx];
      s1_fwd_hit_r  <= wr_en && (wr_idx == in_idx);
      s1_fwd_data_r <= s1_item_r.write_data;
    end
  end

  always_comb begin
    if ((s1_item_r.action == dbrpu_pkg::ACT_READ) && s1_win) begin
      if (s1_fwd_hit_r) begin
        rd_word = s1_fwd_data_r;
      end else if (s1_rvalid_r) begin
        rd_word = ram_rdata;
      end else begin
        rd_word = 32'h0;
      end
    end else begin
      rd_word = 32'h0;
    end
  end

  assign size_w = {1'b0, s1_item_r.write_data[10:0]} + 12'd1;
  assign size_h = {1'b0, s1_item_r.write_data[26:16]} + 12'd1;

  always_comb begin
    mode_nxt   = mode_r;
    base_nxt   = base_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    fmt_nxt    = fmt_r;
    redraw_nxt = redraw_r;
    if (fire) begin
      case (s1_item_r.action)
        dbrpu_pkg::ACT_WRITE: begin
          if (!s1_win) begin
            mode_nxt = mode_r;
          end else if (!mode_r[dbrpu_pkg::MODE_EN_BIT]) begin
            if (s1_item_r.offset == dbrpu_pkg::OFF_MODE) begin
              mode_nxt = s1_item_r.write_data[dbrpu_pkg::MODE_EN_BIT] ?
                         s1_item_r.write_data : 32'h0;
            end
          end else begin
            case (s1_item_r.offset)
              dbrpu_pkg::OFF_MODE: begin
                mode_nxt = s1_item_r.write_data;
                // rising start edge
                if (!mode_r[dbrpu_pkg::MODE_START_BIT] &&
                    s1_item_r.write_data[dbrpu_pkg::MODE_START_BIT]) begin
                  redraw_nxt = 1'b1;
                end
              end
              dbrpu_pkg::OFF_SIZE: begin
                if ((size_w != width_r) || (size_h != height_r)) begin
                  width_nxt  = size_w;
                  height_nxt = size_h;
                  redraw_nxt = 1'b1;
                end
              end
              dbrpu_pkg::OFF_FB_LO: begin
                base_nxt = {base_r[31:29], s1_item_r.write_data[31:3]};
              end
              dbrpu_pkg::OFF_FB_HI: begin
                base_nxt = {s1_item_r.write_data[2:0], base_r[28:0]};
              end
              dbrpu_pkg::OFF_ATT1: begin
                fmt_nxt.code = s1_item_r.write_data[11:8];
                fmt_nxt.opts = s1_item_r.write_data[2:0];
              end
              default: begin
                mode_nxt = mode_r;
              end
            endcase
          end
        end
        dbrpu_pkg::ACT_FRAME: begin
          if ((width_r != 12'd0) && (height_r != 12'd0) &&
              mode_r[dbrpu_pkg::MODE_EN_BIT] && mode_r[dbrpu_pkg::MODE_START_BIT] &&
              (mode_r[11:8] != 4'h0)) begin
            redraw_nxt = 1'b0;
          end
        end
        default: begin
          redraw_nxt = redraw_r;
        end
      endcase
    end
  end

  assign active_nxt = mode_nxt[dbrpu_pkg::MODE_EN_BIT] &&
                      mode_nxt[dbrpu_pkg::MODE_START_BIT] && (mode_nxt[11:8] != 4'h0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 32'h0;
      base_r   <= 32'h0;
      width_r  <= 12'd0;
      height_r <= 12'd0;
      fmt_r    <= '0;
      redraw_r <= 1'b1;
      wvalid_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      base_r   <= base_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      fmt_r    <= fmt_nxt;
      redraw_r <= redraw_nxt;
      if (wr_en) begin
        wvalid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r.read_data       <= rd_word;
      out_item_r.pixel_argb      <= (s1_item_r.action == dbrpu_pkg::ACT_PIXEL) ?
                                    argb : 32'h0;
      out_item_r.refresh_pending <= redraw_nxt;
      out_item_r.layer_width     <= width_nxt;
      out_item_r.layer_height    <= height_nxt;
      out_item_r.frame_base      <= base_nxt;
      out_item_r.output_active   <= active_nxt;
    end
  end

  `DBRPU_ASSERT_IMP(a_ready_only_on_full, !in_ready, s1_valid_r && out_valid_r && !out_ch.ready, "input stalled with room left")
  `DBRPU_ASSERT_NXT(a_s1_held, s1_valid_r && !advance, s1_valid_r, "input stage beat lost on stall")
  `DBRPU_ASSERT_IMP(a_size_pair, width_r == 12'd0, height_r == 12'd0, "layer width and height disagree on zero")
  `DBRPU_ASSERT_NXT(a_state_frozen, !fire, $stable(mode_r) && $stable(base_r) && $stable(redraw_r), "state changed with no beat in flight")

endmodule

`default_nettype wire

@@ rtl/dbrpu_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module dbrpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read during write returns the old word
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/dbrpu_unpack.sv @@
// layer-0 pixel unpacker: source word to argb8888
`timescale 1ns / 1ps
`default_nettype none

module dbrpu_unpack (
  input  wire dbrpu_pkg::fmt_t fmt,
  input  wire logic [31:0]     pixel_word,
  output logic      [31:0]     argb
);

  logic [7:0] a;
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;

  always_comb begin
    a = 8'h00;
    r = 8'h00;
    g = 8'h00;
    b = 8'h00;
    case (fmt.code)
      dbrpu_pkg::FMT_RGB565: begin
        r = {pixel_word[15:11], 3'b000};
        g = {pixel_word[10:5], 2'b00};
        b = {pixel_word[4:0], 3'b000};
      end
      dbrpu_pkg::FMT_RGB0888, dbrpu_pkg::FMT_RGB888: begin
        r = pixel_word[7:0];
        g = pixel_word[15:8];
        b = pixel_word[23:16];
      end
      dbrpu_pkg::FMT_ARGB8888: begin
        r = pixel_word[7:0];
        g = pixel_word[15:8];
        b = pixel_word[23:16];
        a = pixel_word[31:24];
      end
      default: begin
        // unknown format gives black
        a = 8'h00;
      end
    endcase
    if (fmt.opts[dbrpu_pkg::OPT_SWAP_BIT]) begin
      argb = {a, b, g, r};
    end else begin
      argb = {a, r, g, b};
    end
  end

endmodule

`default_nettype wire
